### hw/rtl/mqpd_pkg.sv
// mqpd_pkg: sizes, codes, payload and store interface types for the queue bank
// no dependencies; used by every file in hw/rtl
package mqpd_pkg;

    localparam int NUM_QUEUES  = 32;
    localparam int QUEUE_DEPTH = 8;
    localparam int ID_WIDTH    = 16;

    // queue and slot pointers wrap by truncation, so both counts are powers of two
    localparam int QIDX_W   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_AW   = QIDX_W + PTR_W;
    localparam int NUM_ENTS = NUM_QUEUES * QUEUE_DEPTH;

    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_SERVE = 2'd1;
    localparam logic [1:0] KIND_LIST  = 2'd2;

    localparam logic [2:0] ST_ADDED      = 3'd0;
    localparam logic [2:0] ST_FULL       = 3'd1;
    localparam logic [2:0] ST_SERVED     = 3'd2;
    localparam logic [2:0] ST_EMPTY      = 3'd3;
    localparam logic [2:0] ST_LIST       = 3'd4;
    localparam logic [2:0] ST_LIST_EMPTY = 3'd5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  queue_index;
        logic        urgent;
        logic [15:0] item_id;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] out_id;
        logic        out_urgent;
        logic [3:0]  occupancy;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [PTR_W-1:0] head;
        logic [CNT_W-1:0] cnt;
    } meta_t;

    typedef struct packed {
        logic [ID_WIDTH-1:0] id;
        logic                urg;
    } entry_t;

    typedef struct packed {
        logic              meta_re;
        logic              meta_we;
        logic [QIDX_W-1:0] meta_addr;
        meta_t             meta_wdata;
        logic              ent_re;
        logic              ent_we;
        logic [ENT_AW-1:0] ent_addr;
        entry_t            ent_wdata;
    } store_ctl_t;

    typedef struct packed {
        meta_t  meta;
        entry_t ent;
    } store_rd_t;

endpackage

### hw/rtl/mqpd_store.sv
// mqpd_store: per-queue head/count memory and the entry memory, both with registered reads
// depends on mqpd_pkg
module mqpd_store (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mqpd_pkg::store_ctl_t   ctl,
    output mqpd_pkg::store_rd_t    rd
);

    mqpd_pkg::meta_t  meta_mem [mqpd_pkg::NUM_QUEUES];
    mqpd_pkg::entry_t ent_mem  [mqpd_pkg::NUM_ENTS];

    logic [mqpd_pkg::NUM_QUEUES-1:0] meta_vld_reg;
    logic                            meta_rd_vld_reg;
    mqpd_pkg::meta_t                 meta_rd_reg;
    mqpd_pkg::entry_t                ent_rd_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.meta_we)
        begin
            meta_mem[ctl.meta_addr] <= ctl.meta_wdata;
        end
        if (ctl.meta_re)
        begin
            meta_rd_reg <= meta_mem[ctl.meta_addr];
        end
    end

    // a queue never written reads as head 0, count 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta_vld_reg    <= '0;
            meta_rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (ctl.meta_we)
            begin
                meta_vld_reg[ctl.meta_addr] <= 1'b1;
            end
            if (ctl.meta_re)
            begin
                meta_rd_vld_reg <= meta_vld_reg[ctl.meta_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ent_we)
        begin
            ent_mem[ctl.ent_addr] <= ctl.ent_wdata;
        end
        if (ctl.ent_re)
        begin
            ent_rd_reg <= ent_mem[ctl.ent_addr];
        end
    end

    assign rd.meta = meta_rd_vld_reg ? meta_rd_reg : '0;
    assign rd.ent  = ent_rd_reg;

endmodule

### hw/rtl/multi_queue_priority_deque_top.sv
// multi_queue_priority_deque_top: request sequencer for a bank of bounded deques
// depends on mqpd_pkg and mqpd_store
//
// Keeps 32 queues of up to 8 entries (16-bit id plus urgent mark) in a block
// memory, with head pointer and count per queue in a second memory. An add
// appends at the tail, or at the head when urgent, and answers full when the
// queue holds 8; a serve pops the head or answers empty; a list emits the
// queue head first, last set on the final entry. One request is in work at a
// time: an add, an ignored kind 3 and every empty or full answer finish once
// the head/count read returns, a serve also waits for the entry read that
// follows the head/count read, and a list fetches each next entry while the
// one before goes out. A waiting response holds the next one back. No
// clearing pass after reset: per-queue valid flags make every queue start
// empty at once.
module multi_queue_priority_deque_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  mqpd_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output mqpd_pkg::rsp_t rsp
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_META  = 2'd1;
    localparam logic [1:0] S_SERVE = 2'd2;
    localparam logic [1:0] S_LIST  = 2'd3;

    logic [1:0]                 state_reg, state_next;
    mqpd_pkg::req_t             req_reg, req_next;
    logic [mqpd_pkg::PTR_W-1:0] head_reg, head_next;
    logic [mqpd_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [mqpd_pkg::PTR_W-1:0] idx_reg, idx_next;
    logic                       rsp_valid_reg, rsp_valid_next;
    mqpd_pkg::rsp_t             rsp_reg, rsp_next;

    mqpd_pkg::store_ctl_t ctl;
    mqpd_pkg::store_rd_t  rd;

    logic                        out_free;
    logic [mqpd_pkg::QIDX_W-1:0] q;
    logic [mqpd_pkg::PTR_W-1:0]  m_head;
    logic [mqpd_pkg::CNT_W-1:0]  m_cnt;
    logic [mqpd_pkg::PTR_W-1:0]  new_head;

    mqpd_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .rd    (rd)
    );

    function automatic mqpd_pkg::rsp_t make_rsp(
        input logic [2:0]                 status,
        input mqpd_pkg::entry_t           ent,
        input logic [mqpd_pkg::CNT_W-1:0] occ,
        input logic                       last
    );
        mqpd_pkg::rsp_t r;
        r.status     = status;
        r.out_id     = 16'(ent.id);
        r.out_urgent = ent.urg;
        r.occupancy  = 4'(occ);
        r.last       = last;
        return r;
    endfunction

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign q         = req_reg.queue_index[mqpd_pkg::QIDX_W-1:0];
    assign m_head    = rd.meta.head;
    assign m_cnt     = rd.meta.cnt;
    assign new_head  = m_head - mqpd_pkg::PTR_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        head_next      = head_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        ctl            = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next      = req;
                    ctl.meta_re   = 1'b1;
                    ctl.meta_addr = req.queue_index[mqpd_pkg::QIDX_W-1:0];
                    state_next    = S_META;
                end
            end
            S_META:
            begin
                ctl.meta_addr = q;
                case (req_reg.kind)
                    mqpd_pkg::KIND_ADD:
                    begin
                        if (out_free)
                        begin
                            rsp_valid_next = 1'b1;
                            state_next     = S_IDLE;
                            if (m_cnt == mqpd_pkg::CNT_W'(mqpd_pkg::QUEUE_DEPTH))
                            begin
                                rsp_next = make_rsp(mqpd_pkg::ST_FULL, '0, m_cnt, 1'b1);
                            end
                            else
                            begin
                                ctl.ent_we        = 1'b1;
                                ctl.ent_wdata.id  = mqpd_pkg::ID_WIDTH'(req_reg.item_id);
                                ctl.ent_wdata.urg = req_reg.urgent;
                                ctl.meta_we       = 1'b1;
                                ctl.meta_wdata.cnt = m_cnt + mqpd_pkg::CNT_W'(1);
                                if (req_reg.urgent)
                                begin
                                    ctl.ent_addr        = {q, new_head};
                                    ctl.meta_wdata.head = new_head;
                                end
                                else
                                begin
                                    ctl.ent_addr = {q, mqpd_pkg::PTR_W'(m_head
                                        + m_cnt[mqpd_pkg::PTR_W-1:0])};
                                    ctl.meta_wdata.head = m_head;
                                end
                                rsp_next = make_rsp(mqpd_pkg::ST_ADDED, '0,
                                    ctl.meta_wdata.cnt, 1'b1);
                            end
                        end
                    end
                    mqpd_pkg::KIND_SERVE:
                    begin
                        if (m_cnt == '0)
                        begin
                            if (out_free)
                            begin
                                rsp_valid_next = 1'b1;
                                rsp_next   = make_rsp(mqpd_pkg::ST_EMPTY, '0, '0, 1'b1);
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            ctl.ent_re          = 1'b1;
                            ctl.ent_addr        = {q, m_head};
                            ctl.meta_we         = 1'b1;
                            ctl.meta_wdata.head = m_head + mqpd_pkg::PTR_W'(1);
                            ctl.meta_wdata.cnt  = m_cnt - mqpd_pkg::CNT_W'(1);
                            cnt_next            = ctl.meta_wdata.cnt;
                            state_next          = S_SERVE;
                        end
                    end
                    mqpd_pkg::KIND_LIST:
                    begin
                        if (m_cnt == '0)
                        begin
                            if (out_free)
                            begin
                                rsp_valid_next = 1'b1;
                                rsp_next = make_rsp(mqpd_pkg::ST_LIST_EMPTY, '0, '0, 1'b1);
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            ctl.ent_re   = 1'b1;
                            ctl.ent_addr = {q, m_head};
                            head_next    = m_head;
                            cnt_next     = m_cnt;
                            idx_next     = '0;
                            state_next   = S_LIST;
                        end
                    end
                    default:
                    begin
                        // unused kind: no state change, no response
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SERVE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next   = make_rsp(mqpd_pkg::ST_SERVED, rd.ent, cnt_reg, 1'b1);
                    state_next = S_IDLE;
                end
            end
            S_LIST:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    if (mqpd_pkg::CNT_W'(idx_reg) + mqpd_pkg::CNT_W'(1) == cnt_reg)
                    begin
                        rsp_next   = make_rsp(mqpd_pkg::ST_LIST, rd.ent, cnt_reg, 1'b1);
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rsp_next = make_rsp(mqpd_pkg::ST_LIST, rd.ent, cnt_reg, 1'b0);
                        // fetch the next entry while this one goes out
                        ctl.ent_re   = 1'b1;
                        ctl.ent_addr = {q, mqpd_pkg::PTR_W'(head_reg + idx_reg
                            + mqpd_pkg::PTR_W'(1))};
                        idx_next     = idx_reg + mqpd_pkg::PTR_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        head_reg <= head_next;
        cnt_reg  <= cnt_next;
        idx_reg  <= idx_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### hw/rtl/mqpd_checker.sv
// mqpd_checker: port-level checks on the queue bank, bound to the top level
// depends on mqpd_pkg and multi_queue_priority_deque_top
module mqpd_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input mqpd_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input mqpd_pkg::rsp_t rsp
);

    // a stalled response holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // one request in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another is in work");

    // only list entries may be non-final, only served and listed items carry an id
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != mqpd_pkg::ST_LIST && rsp.status != mqpd_pkg::ST_SERVED
        |-> rsp.last && rsp.out_id == '0 && !rsp.out_urgent)
        else $error("bad response for non-item status");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.status <= mqpd_pkg::ST_LIST_EMPTY
            && rsp.occupancy <= 4'(mqpd_pkg::QUEUE_DEPTH))
        else $error("status or occupancy out of range");

endmodule

bind multi_queue_priority_deque_top mqpd_checker u_mqpd_checker (.*);

### tb/sv/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for multi_queue_priority_deque_top (add, serve, list on a deque bank)
// depends on mqpd_pkg and the rtl under hw/rtl; predicts responses from its own queue state or fixed plan values
module tb;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 415;
    localparam int QUIET_FROM   = 360;
    localparam int DRAIN_AT     = 300;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 20;

    typedef struct {
        mqpd_pkg::req_t r;
        bit             fixed;
        mqpd_pkg::rsp_t want;
    } plan_row_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_ready;
    mqpd_pkg::req_t req = '0;
    logic           rsp_valid;
    logic           rsp_ready = 1'b0;
    mqpd_pkg::rsp_t rsp;

    // mirror of the queue bank
    logic [mqpd_pkg::ID_WIDTH-1:0] slot_id  [mqpd_pkg::NUM_ENTS];
    logic                          slot_urg [mqpd_pkg::NUM_ENTS];
    logic [mqpd_pkg::PTR_W-1:0]    q_head   [mqpd_pkg::NUM_QUEUES];
    logic [mqpd_pkg::CNT_W-1:0]    q_cnt    [mqpd_pkg::NUM_QUEUES];

    mqpd_pkg::rsp_t op_results[$];
    mqpd_pkg::rsp_t awaited_rsp[$];
    plan_row_t      directed_plan[$];
    int unsigned    accepted_reqs = 0;
    int unsigned    fail_count = 0;
    bit             quiet = 1'b0;

    multi_queue_priority_deque_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5000000;
        $display("[multi_queue_priority_deque_top] ERROR");
        $finish;
    end

    function automatic mqpd_pkg::rsp_t fixed_rsp(logic [2:0] st, logic [15:0] id, logic u,
                                                 logic [3:0] occ);
        mqpd_pkg::rsp_t o;
        o.status     = st;
        o.out_id     = id;
        o.out_urgent = u;
        o.occupancy  = occ;
        o.last       = 1'b1;
        return o;
    endfunction

    function automatic void plan_row(logic [1:0] k, logic [4:0] q, logic u, logic [15:0] id,
                                     bit fixed, mqpd_pkg::rsp_t want);
        plan_row_t p;
        p.r.kind        = k;
        p.r.queue_index = q;
        p.r.urgent      = u;
        p.r.item_id     = id;
        p.fixed         = fixed;
        p.want          = want;
        directed_plan.push_back(p);
    endfunction

    // updates the mirror for one request and leaves its responses in op_results
    function automatic void apply_queue_op(mqpd_pkg::req_t r);
        logic [mqpd_pkg::QIDX_W-1:0] q;
        logic [mqpd_pkg::PTR_W-1:0]  hd;
        logic [mqpd_pkg::PTR_W-1:0]  pos;
        logic [mqpd_pkg::CNT_W-1:0]  cnt;
        logic [mqpd_pkg::ENT_AW-1:0] slot;
        mqpd_pkg::rsp_t              o;
        q   = r.queue_index;
        hd  = q_head[q];
        cnt = q_cnt[q];
        o   = '0;
        o.last = 1'b1;
        op_results.delete();
        case (r.kind)
            mqpd_pkg::KIND_ADD:
            begin
                if (cnt >= mqpd_pkg::QUEUE_DEPTH)
                begin
                    o.status    = mqpd_pkg::ST_FULL;
                    o.occupancy = 4'(mqpd_pkg::QUEUE_DEPTH);
                end
                else
                begin
                    if (r.urgent)
                    begin
                        hd = hd - 1'b1;
                        q_head[q] = hd;
                        pos = hd;
                    end
                    else
                    begin
                        pos = mqpd_pkg::PTR_W'(hd + cnt);
                    end
                    slot = {q, pos};
                    slot_id[slot]  = r.item_id;
                    slot_urg[slot] = r.urgent;
                    q_cnt[q]    = cnt + 1'b1;
                    o.status    = mqpd_pkg::ST_ADDED;
                    o.occupancy = 4'(cnt + 1'b1);
                end
                op_results.push_back(o);
            end
            mqpd_pkg::KIND_SERVE:
            begin
                if (cnt == 0)
                begin
                    o.status = mqpd_pkg::ST_EMPTY;
                end
                else
                begin
                    slot = {q, hd};
                    o.status     = mqpd_pkg::ST_SERVED;
                    o.out_id     = slot_id[slot];
                    o.out_urgent = slot_urg[slot];
                    o.occupancy  = 4'(cnt - 1'b1);
                    q_head[q] = hd + 1'b1;
                    q_cnt[q]  = cnt - 1'b1;
                end
                op_results.push_back(o);
            end
            mqpd_pkg::KIND_LIST:
            begin
                if (cnt == 0)
                begin
                    o.status = mqpd_pkg::ST_LIST_EMPTY;
                    op_results.push_back(o);
                end
                else
                begin
                    for (int i = 0; i < cnt; i++)
                    begin
                        pos  = mqpd_pkg::PTR_W'(hd + i);
                        slot = {q, pos};
                        o.status     = mqpd_pkg::ST_LIST;
                        o.out_id     = slot_id[slot];
                        o.out_urgent = slot_urg[slot];
                        o.occupancy  = 4'(cnt);
                        o.last       = (i == cnt - 1);
                        op_results.push_back(o);
                    end
                end
            end
            default:
            begin
                // unused kind: no state change, no response
            end
        endcase
    endfunction

    // drive one request, hold it until taken, then record what it should produce
    task automatic issue(mqpd_pkg::req_t r, bit fixed, mqpd_pkg::rsp_t want);
        req       <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        accepted_reqs++;
        apply_queue_op(r);
        if (fixed)
            awaited_rsp.push_back(want);
        else
            foreach (op_results[i]) awaited_rsp.push_back(op_results[i]);
    endtask

    task automatic sender_gap(bit drain);
        if (drain)
        begin
            req_valid <= 1'b0;
            do @(posedge clk); while (awaited_rsp.size() != 0);
        end
        else if (!quiet && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    initial
    begin : req_side
        int unsigned    n_rand;
        int unsigned    roll;
        int unsigned    add_pct;
        int unsigned    serve_pct;
        logic [4:0]     hot [4];
        mqpd_pkg::req_t r;
        mqpd_pkg::rsp_t none;

        none = '0;
        foreach (q_head[i])
        begin
            q_head[i] = '0;
            q_cnt[i]  = '0;
        end

        plan_row(mqpd_pkg::KIND_SERVE, 5'd0, 1'b0, 16'h0000, 1'b1,
                 fixed_rsp(mqpd_pkg::ST_EMPTY, 16'h0, 1'b0, 4'd0));
        plan_row(mqpd_pkg::KIND_LIST, 5'd31, 1'b1, 16'hFFFF, 1'b1,
                 fixed_rsp(mqpd_pkg::ST_LIST_EMPTY, 16'h0, 1'b0, 4'd0));
        plan_row(KIND_UNUSED, 5'd5, 1'b0, 16'h1234, 1'b0, none);
        plan_row(mqpd_pkg::KIND_ADD, 5'd0, 1'b0, 16'h0000, 1'b1,
                 fixed_rsp(mqpd_pkg::ST_ADDED, 16'h0, 1'b0, 4'd1));
        plan_row(mqpd_pkg::KIND_ADD, 5'd0, 1'b1, 16'hFFFF, 1'b1,
                 fixed_rsp(mqpd_pkg::ST_ADDED, 16'h0, 1'b0, 4'd2));
        plan_row(mqpd_pkg::KIND_LIST, 5'd0, 1'b0, 16'h0000, 1'b0, none);
        plan_row(mqpd_pkg::KIND_SERVE, 5'd0, 1'b0, 16'h0000, 1'b1,
                 fixed_rsp(mqpd_pkg::ST_SERVED, 16'hFFFF, 1'b1, 4'd1));
        for (int i = 0; i < mqpd_pkg::QUEUE_DEPTH; i++)
            plan_row(mqpd_pkg::KIND_ADD, 5'd31, i[0], 16'(16'hA5A0 + i), 1'b0, none);
        // adds to a full queue are dropped whichever end they aim at
        plan_row(mqpd_pkg::KIND_ADD, 5'd31, 1'b0, 16'h5A5A, 1'b1,
                 fixed_rsp(mqpd_pkg::ST_FULL, 16'h0, 1'b0, 4'd8));
        plan_row(mqpd_pkg::KIND_ADD, 5'd31, 1'b1, 16'hFFFF, 1'b1,
                 fixed_rsp(mqpd_pkg::ST_FULL, 16'h0, 1'b0, 4'd8));
        plan_row(mqpd_pkg::KIND_LIST, 5'd31, 1'b0, 16'h0000, 1'b0, none);
        plan_row(mqpd_pkg::KIND_SERVE, 5'd31, 1'b0, 16'h0000, 1'b0, none);
        plan_row(mqpd_pkg::KIND_SERVE, 5'd0, 1'b0, 16'h0000, 1'b1,
                 fixed_rsp(mqpd_pkg::ST_SERVED, 16'h0, 1'b0, 4'd0));
        plan_row(mqpd_pkg::KIND_SERVE, 5'd0, 1'b0, 16'h0000, 1'b1,
                 fixed_rsp(mqpd_pkg::ST_EMPTY, 16'h0, 1'b0, 4'd0));
        plan_row(KIND_UNUSED, 5'd31, 1'b1, 16'hFFFF, 1'b0, none);
        plan_row(mqpd_pkg::KIND_LIST, 5'd31, 1'b0, 16'h0000, 1'b0, none);
        plan_row(mqpd_pkg::KIND_ADD, 5'd15, 1'b1, 16'h8001, 1'b0, none);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
        begin
            issue(directed_plan[i].r, directed_plan[i].fixed, directed_plan[i].want);
            sender_gap(1'b0);
        end

        n_rand = 0;
        foreach (hot[j]) hot[j] = 5'($urandom_range(0, 31));
        add_pct   = 60;
        serve_pct = 20;
        while (n_rand < RANDOM_ITEMS)
        begin
            // alternate fill and drain phases so queues hit full, empty and wrap
            if (n_rand % 40 == 0)
            begin
                foreach (hot[j]) hot[j] = 5'($urandom_range(0, 31));
                if ((n_rand / 40) % 2 == 0)
                begin
                    add_pct   = 60;
                    serve_pct = 20;
                end
                else
                begin
                    add_pct   = 25;
                    serve_pct = 55;
                end
            end
            roll = $urandom_range(0, 99);
            if (roll < add_pct)
                r.kind = mqpd_pkg::KIND_ADD;
            else if (roll < add_pct + serve_pct)
                r.kind = mqpd_pkg::KIND_SERVE;
            else if (roll < 95)
                r.kind = mqpd_pkg::KIND_LIST;
            else
                r.kind = KIND_UNUSED;
            r.queue_index = ($urandom_range(0, 9) < 8) ? hot[$urandom_range(0, 3)]
                                                       : 5'($urandom_range(0, 31));
            r.urgent = 1'($urandom_range(0, 1));
            roll = $urandom_range(0, 9);
            if (roll == 0)
                r.item_id = 16'h0000;
            else if (roll == 1)
                r.item_id = 16'hFFFF;
            else
                r.item_id = 16'($urandom);
            issue(r, 1'b0, none);
            if (r.kind != KIND_UNUSED)
                n_rand++;
            quiet = (n_rand >= QUIET_FROM);
            sender_gap(n_rand == DRAIN_AT && r.kind != KIND_UNUSED);
        end

        if (req_valid)
            req_valid <= 1'b0;
        do @(posedge clk); while (awaited_rsp.size() != 0);
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("[multi_queue_priority_deque_top] OK");
        else
            $display("[multi_queue_priority_deque_top] ERROR");
        $finish;
    end

    initial
    begin : rsp_side
        bit held_once;
        held_once = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!held_once && accepted_reqs >= HOLD_AT)
            begin
                // long back-pressure so the request side stalls
                held_once = 1'b1;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            else
            begin
                rsp_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        mqpd_pkg::rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (awaited_rsp.size() == 0)
            begin
                $error("response with nothing outstanding: status %0h id %0h",
                       rsp.status, rsp.out_id);
                fail_count++;
            end
            else
            begin
                want = awaited_rsp.pop_front();
                check_field("status", 16'(want.status), 16'(rsp.status));
                check_field("out_id", want.out_id, rsp.out_id);
                check_field("out_urgent", 16'(want.out_urgent), 16'(rsp.out_urgent));
                check_field("occupancy", 16'(want.occupancy), 16'(rsp.occupancy));
                check_field("last", 16'(want.last), 16'(rsp.last));
            end
        end
    end

endmodule
